// File: hw/rtl/mfpe_pkg.sv
// Shared types and constants for the motion-capture frame pose extractor.
package mfpe_pkg;

    localparam int          POSE_WORDS   = 7;
    localparam logic [15:0] MSG_FRAME    = 16'd7;
    localparam logic [15:0] MAX_ID_RESET = 16'd255;
    localparam int          OUT_BITS     = 296;

    typedef enum logic [1:0] {
        KIND_POSE      = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_NOT_FRAME = 2'd2,
        KIND_TRUNC     = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_MSGID     = 5'd0,
        PH_SIZE      = 5'd1,
        PH_FRAME     = 5'd2,
        PH_NSETS     = 5'd3,
        PH_NAME      = 5'd4,
        PH_NMARK     = 5'd5,
        PH_SKIPSET   = 5'd6,
        PH_NOTHER    = 5'd7,
        PH_SKIPOTHER = 5'd8,
        PH_NRB       = 5'd9,
        PH_RBID      = 5'd10,
        PH_POSE      = 5'd11,
        PH_RBNMARK   = 5'd12,
        PH_RBSKIP    = 5'd13,
        PH_RBERR     = 5'd14,
        PH_NSKEL     = 5'd15,
        PH_SKID      = 5'd16,
        PH_SKNB      = 5'd17,
        PH_LAT       = 5'd18,
        PH_EOD       = 5'd19,
        PH_DONE      = 5'd20,
        PH_IGNORE    = 5'd21
    } t_phase;

    typedef struct packed {
        t_kind                          kind;
        logic [31:0]                    frame_number;
        logic [31:0]                    body_id;
        logic                           id_valid;
        logic [POSE_WORDS-1:0][31:0]    pose;
    } t_result;

endpackage

// File: hw/rtl/mocap_frame_pose_extractor.sv
// Top level: datagram byte stream in, pose and frame status results out.
//
// Usage:
// - s_axis carries one datagram byte per transaction in tdata, tlast on the
//   final byte. One byte is taken every cycle while s_axis_tready is high.
// - m_axis carries results: tuser is the result kind (pose, frame complete,
//   not a frame packet, truncated); tdata holds frame number, body ID, ID
//   valid flag and the seven raw pose words.
// - A pose result follows the byte that completes a top-level rigid body's
//   seventh pose word; a status result follows every tlast byte.
// - A result is registered into the output register, or into the skid register while m_axis stalls.
// - Throughput: one byte per cycle while s_axis_tready is high, set by the single parser register stage.
// - The config channel writes max_object_id at any cycle; cfg ready is
//   always high. Write it only while the stream is idle.
// - Reset clears the parser to expect a message ID, empties the output and
//   skid registers and loads max_object_id with 255.
// - When m_axis stalls, one further result is held in a skid register;
//   s_axis_tready drops only while that skid register is occupied.
module mocap_frame_pose_extractor
    import mfpe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] frame_number, [63:32] body_id, [64] id_valid, [96:65] pos_x_bits,
    // [128:97] pos_y_bits, [160:129] pos_z_bits, [192:161] quat_x_bits,
    // [224:193] quat_y_bits, [256:225] quat_z_bits, [288:257] quat_w_bits
    output logic [OUT_BITS-1:0] m_axis_tdata,
    output logic [1:0]          m_axis_tuser,   // [1:0] result_kind
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic [15:0] r_max_id;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_fire;
    logic        out_fire;
    logic        res_valid;
    t_result     res;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign out_fire    = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_id <= MAX_ID_RESET;
        end else if (i_cfg_valid) begin
            r_max_id <= i_cfg_data;
        end
    end

    mfpe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_fire),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_max_id    (r_max_id),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire || !r_out_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire || !r_out_valid) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {7'd0, r_out.pose, r_out.id_valid, r_out.body_id,
                            r_out.frame_number};

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register occupied while output register empty");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result pending after end of datagram");

    a_status_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_POSE |->
            r_out.body_id == 32'd0 && !r_out.id_valid)
        else $error("status result carries body fields");

endmodule

// File: hw/rtl/mfpe_parser.sv
// Byte-wise frame parser: phase state, word assembly, counters and pose capture.
module mfpe_parser
    import mfpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_max_id,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_bcnt, n_bcnt;
    logic [31:0] r_shift, n_shift;
    logic [15:0] r_msg, n_msg;
    logic [31:0] r_frame, n_frame;
    logic [31:0] r_outer, n_outer;
    logic [31:0] r_inner, n_inner;
    logic [35:0] r_skip, n_skip;
    logic [31:0] r_cur_id, n_cur_id;
    logic        r_in_skel, n_in_skel;
    logic [2:0]  r_pidx, n_pidx;
    logic [31:0] r_pose [POSE_WORDS];
    logic [31:0] n_pose [POSE_WORDS];

    logic [31:0] sh;
    logic [1:0]  cnt_inc;
    logic [31:0] w_count;
    logic [35:0] w_x12;
    logic [35:0] w_x20;
    logic        pose_done;
    t_kind       end_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MSGID;
            r_bcnt    <= '0;
            r_shift   <= '0;
            r_msg     <= '0;
            r_frame   <= '0;
            r_outer   <= '0;
            r_inner   <= '0;
            r_skip    <= '0;
            r_cur_id  <= '0;
            r_in_skel <= 1'b0;
            r_pidx    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_bcnt    <= n_bcnt;
            r_shift   <= n_shift;
            r_msg     <= n_msg;
            r_frame   <= n_frame;
            r_outer   <= n_outer;
            r_inner   <= n_inner;
            r_skip    <= n_skip;
            r_cur_id  <= n_cur_id;
            r_in_skel <= n_in_skel;
            r_pidx    <= n_pidx;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < POSE_WORDS; i++) begin
            r_pose[i] <= n_pose[i];
        end
    end

    assign sh      = {i_byte, r_shift[31:8]};
    assign cnt_inc = r_bcnt + 2'd1;
    assign w_count = sh[31] ? 32'd0 : sh;
    assign w_x12   = ({4'd0, w_count} << 3) + ({4'd0, w_count} << 2);
    assign w_x20   = ({4'd0, w_count} << 4) + ({4'd0, w_count} << 2);

    always_comb begin
        n_phase   = r_phase;
        n_bcnt    = r_bcnt;
        n_shift   = r_shift;
        n_msg     = r_msg;
        n_frame   = r_frame;
        n_outer   = r_outer;
        n_inner   = r_inner;
        n_skip    = r_skip;
        n_cur_id  = r_cur_id;
        n_in_skel = r_in_skel;
        n_pidx    = r_pidx;
        for (int i = 0; i < POSE_WORDS; i++) begin
            n_pose[i] = r_pose[i];
        end
        pose_done   = 1'b0;
        end_kind    = KIND_TRUNC;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_MSGID: begin
                    n_shift = sh;
                    n_bcnt  = cnt_inc;
                    if (cnt_inc == 2'd2) begin
                        n_msg   = sh[31:16];
                        n_phase = PH_SIZE;
                        n_bcnt  = '0;
                    end
                end
                PH_SIZE: begin
                    n_shift = sh;
                    n_bcnt  = cnt_inc;
                    if (cnt_inc == 2'd2) begin
                        n_phase = (r_msg == MSG_FRAME) ? PH_FRAME : PH_IGNORE;
                        n_bcnt  = '0;
                    end
                end
                PH_NAME: begin
                    if (i_byte == 8'd0) begin
                        n_phase = PH_NMARK;
                        n_bcnt  = '0;
                    end
                end
                PH_SKIPSET, PH_SKIPOTHER, PH_RBSKIP: begin
                    n_skip = r_skip - {35'd0, (r_skip != 36'd0)};
                    if (n_skip == 36'd0) begin
                        n_bcnt = '0;
                        if (r_phase == PH_SKIPSET) begin
                            if (r_outer == 32'd0) begin
                                n_phase = PH_NOTHER;
                            end else begin
                                n_outer = r_outer - 32'd1;
                                n_phase = PH_NAME;
                            end
                        end else if (r_phase == PH_SKIPOTHER) begin
                            n_phase = PH_NRB;
                        end else begin
                            n_phase = PH_RBERR;
                        end
                    end
                end
                PH_DONE, PH_IGNORE: begin
                end
                PH_FRAME, PH_NSETS, PH_NMARK, PH_NOTHER, PH_NRB, PH_RBID, PH_POSE,
                PH_RBNMARK, PH_RBERR, PH_NSKEL, PH_SKID, PH_SKNB, PH_LAT,
                PH_EOD: begin
                    n_shift = sh;
                    n_bcnt  = cnt_inc;
                    if (cnt_inc == 2'd0) begin
                        unique case (r_phase)
                            PH_FRAME: begin
                                n_frame = sh;
                                n_phase = PH_NSETS;
                            end
                            PH_NSETS: begin
                                if (w_count == 32'd0) begin
                                    n_outer = '0;
                                    n_phase = PH_NOTHER;
                                end else begin
                                    n_outer = w_count - 32'd1;
                                    n_phase = PH_NAME;
                                end
                            end
                            PH_NMARK: begin
                                n_skip = w_x12;
                                if (w_count != 32'd0) begin
                                    n_phase = PH_SKIPSET;
                                end else if (r_outer == 32'd0) begin
                                    n_phase = PH_NOTHER;
                                end else begin
                                    n_outer = r_outer - 32'd1;
                                    n_phase = PH_NAME;
                                end
                            end
                            PH_NOTHER: begin
                                n_skip  = w_x12;
                                n_phase = (w_count == 32'd0) ? PH_NRB : PH_SKIPOTHER;
                            end
                            PH_NRB: begin
                                n_in_skel = 1'b0;
                                if (w_count == 32'd0) begin
                                    n_outer = '0;
                                    n_phase = PH_NSKEL;
                                end else begin
                                    n_outer = w_count - 32'd1;
                                    n_phase = PH_RBID;
                                end
                            end
                            PH_RBID: begin
                                n_cur_id = sh;
                                n_pidx   = '0;
                                n_phase  = PH_POSE;
                            end
                            PH_POSE: begin
                                n_pose[r_pidx] = sh;
                                n_pidx         = r_pidx + 3'd1;
                                if (r_pidx == 3'(POSE_WORDS - 1)) begin
                                    n_pidx    = '0;
                                    pose_done = !r_in_skel;
                                    n_phase   = PH_RBNMARK;
                                end
                            end
                            PH_RBNMARK: begin
                                n_skip  = w_x20;
                                n_phase = (w_count == 32'd0) ? PH_RBERR : PH_RBSKIP;
                            end
                            PH_RBERR: begin
                                if (r_in_skel) begin
                                    if (r_inner != 32'd0) begin
                                        n_inner = r_inner - 32'd1;
                                        n_phase = PH_RBID;
                                    end else if (r_outer == 32'd0) begin
                                        n_phase = PH_LAT;
                                    end else begin
                                        n_outer = r_outer - 32'd1;
                                        n_phase = PH_SKID;
                                    end
                                end else if (r_outer == 32'd0) begin
                                    n_phase = PH_NSKEL;
                                end else begin
                                    n_outer = r_outer - 32'd1;
                                    n_phase = PH_RBID;
                                end
                            end
                            PH_NSKEL: begin
                                n_in_skel = 1'b1;
                                if (w_count == 32'd0) begin
                                    n_outer = '0;
                                    n_phase = PH_LAT;
                                end else begin
                                    n_outer = w_count - 32'd1;
                                    n_phase = PH_SKID;
                                end
                            end
                            PH_SKID: n_phase = PH_SKNB;
                            PH_SKNB: begin
                                if (w_count != 32'd0) begin
                                    n_inner = w_count - 32'd1;
                                    n_phase = PH_RBID;
                                end else begin
                                    n_inner = '0;
                                    if (r_outer == 32'd0) begin
                                        n_phase = PH_LAT;
                                    end else begin
                                        n_outer = r_outer - 32'd1;
                                        n_phase = PH_SKID;
                                    end
                                end
                            end
                            PH_LAT:  n_phase = PH_EOD;
                            PH_EOD:  n_phase = PH_DONE;
                            default: n_phase = PH_IGNORE;
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_IGNORE;
                    n_bcnt  = '0;
                end
            endcase

            if (i_last) begin
                priority if (n_phase == PH_DONE) begin
                    end_kind = KIND_DONE;
                end else if (n_phase != PH_MSGID && n_msg != MSG_FRAME) begin
                    end_kind = KIND_NOT_FRAME;
                end else begin
                    end_kind = KIND_TRUNC;
                end
                o_res_valid        = 1'b1;
                o_res.kind         = end_kind;
                o_res.frame_number = n_frame;

                n_phase   = PH_MSGID;
                n_bcnt    = '0;
                n_shift   = '0;
                n_msg     = '0;
                n_frame   = '0;
                n_outer   = '0;
                n_inner   = '0;
                n_skip    = '0;
                n_cur_id  = '0;
                n_in_skel = 1'b0;
                n_pidx    = '0;
            end else if (pose_done) begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_POSE;
                o_res.frame_number = n_frame;
                o_res.body_id      = r_cur_id;
                o_res.id_valid     = (r_cur_id <= {16'd0, i_max_id});
                for (int i = 0; i < POSE_WORDS; i++) begin
                    o_res.pose[i] = n_pose[i];
                end
            end
        end
    end

endmodule
